@@ hdl/wtu_pkg.sv @@
// Shared types and constants for the Wegstein tear-variable update block.
// Used by every module of the block but wtu_ram; depends on nothing.
`timescale 1ns / 1ps

package wtu_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_VARS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Queue between front and back
    localparam int Q_DEPTH = 2;

    // Register map (index = byte address / 8)
    localparam logic [1:0] REG_ABS_TOL   = 2'd0;
    localparam logic [1:0] REG_REL_TOL   = 2'd1;
    localparam logic [1:0] REG_NEAR_ZERO = 2'd2;

    // Register reset values
    localparam logic [62:0] ABS_TOL_RST   = 63'd43;
    localparam logic [31:0] REL_TOL_RST   = 32'd4295;
    localparam logic [15:0] NEAR_ZERO_RST = 16'd1;

    // Request codes
    localparam logic REQ_INIT   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // 1.0 in Q32.32 and in Q1.32
    localparam logic signed [65:0] ONE_Q32_W = 66'sd4294967296;
    localparam logic [32:0]        ONE_Q1_32 = 33'h1_0000_0000;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         var_index;
        logic signed [63:0] input_guess;
        logic signed [63:0] computed_value;
        logic               end_of_sweep;
    } t_item;

    typedef struct packed {
        logic signed [63:0] next_guess;
        logic               var_converged;
        logic               sweep_done;
        logic               sweep_converged;
    } t_result;

    typedef struct packed {
        logic [62:0] abs_tol;
        logic [31:0] rel_tol;
        logic [15:0] near_zero_band;
    } t_cfg;

    // Classified item as held in the queue (address kept at full index width)
    typedef struct packed {
        logic               is_update;
        logic               in_range;
        logic [5:0]         idx;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic               eos;
    } t_cmd;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Back part status toward the front part
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

    // Magnitude of a two's complement word (most negative maps to 2^63)
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

endpackage

@@ hdl/wtu_ram.sv @@
// Generic RAM with one write port, one read port and registered read.
// No dependencies.
`timescale 1ns / 1ps

module wtu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/wtu_front.sv @@
// Front part: accepts items, classifies them and holds them in a short queue.
// Depends on wtu_pkg.
`timescale 1ns / 1ps

module wtu_front #(
    parameter int NUM_VARS = wtu_pkg::NUM_VARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  wtu_pkg::t_item     i_item,
    output logic               o_busy,
    input  wtu_pkg::t_back_stat i_stat,
    output wtu_pkg::t_q_head   o_head
);
    import wtu_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_cmd           r_q [Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PW:0]    r_count;
    logic           push, pop;
    t_cmd           cmd_in;

    // Classify the incoming item
    always_comb begin
        cmd_in.is_update = (i_item.req_type == REQ_UPDATE);
        cmd_in.in_range  = (32'(i_item.var_index) < 32'(NUM_VARS));
        cmd_in.idx       = i_item.var_index;
        cmd_in.x         = i_item.input_guess;
        cmd_in.y         = i_item.computed_value;
        cmd_in.eos       = i_item.end_of_sweep;
    end

    assign o_busy = (r_count == (PW+1)'(Q_DEPTH)) || i_stat.clearing;
    assign push   = i_start && !o_busy;
    assign pop    = i_stat.pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

@@ hdl/wtu_back.sv @@
// Back part: error memory, slope division, products, saturation and
// convergence flags. Depends on wtu_pkg and wtu_ram.
`timescale 1ns / 1ps

module wtu_back #(
    parameter int NUM_VARS   = wtu_pkg::NUM_VARS_DEF,
    parameter int VALUE_BITS = wtu_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wtu_pkg::t_cfg       i_cfg,
    input  wtu_pkg::t_q_head    i_head,
    output wtu_pkg::t_back_stat o_stat,
    output logic                o_result_valid,
    output wtu_pkg::t_result    o_result
);
    import wtu_pkg::*;

    localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (VALUE_BITS-1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -(66'sd1 <<< (VALUE_BITS-1));

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_INIT, S_ERR, S_DIFF, S_QSEL, S_DIV,
        S_MUL1, S_MUL2, S_SUM, S_OUT
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    t_cmd               r_cmd;
    logic signed [63:0] r_e, r_ep;
    logic [63:0]        r_em, r_epm, r_dm, r_xm, r_rem, r_pm;
    logic               r_dneg, r_conv, r_sweep_ok, r_res_valid;
    logic [32:0]        r_qm;
    logic [4:0]         r_cnt;
    logic [64:0]        r_p_hi, r_p_lo;
    logic [63:0]        r_r_lo, r_r_hi;
    t_result            r_res;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

    logic signed [65:0] diff_w, d_w, sum_w, g_w;
    logic signed [63:0] e_sat, ep_rd;
    logic [64:0]        div_r2;
    logic               div_bit;
    logic [95:0]        rel_prod;
    logic               rel_ok, abs_ok, add_neg;

    // Saturate a wide signed value to the value range
    function automatic logic signed [63:0] sat(input logic signed [65:0] v);
        logic signed [65:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[63:0];
    endfunction

    wtu_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_VARS), .AW(AW)) u_err_mem (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Error of this pass, saturated
    assign diff_w = 66'(r_cmd.y) - 66'(r_cmd.x);
    assign e_sat  = sat(diff_w);
    assign ep_rd  = r_cmd.in_range ? 64'(signed'(ram_rdata)) : 64'sd0;

    // Memory ports
    always_comb begin
        ram_raddr = AW'(i_head.cmd.idx);
        ram_waddr = AW'(r_cmd.idx);
        ram_wdata = '0;
        ram_we    = 1'b0;
        unique case (r_state)
            S_CLR: begin
                ram_waddr = r_clr_addr;
                ram_we    = 1'b1;
            end
            S_INIT: ram_we = r_cmd.in_range;
            S_ERR: begin
                ram_we    = r_cmd.in_range;
                ram_wdata = e_sat[VALUE_BITS-1:0];
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Datapath pieces
    assign d_w     = 66'(r_e) - 66'(r_ep);
    assign div_r2  = {r_rem, 1'b0};
    assign div_bit = (div_r2 >= {1'b0, r_dm});
    assign rel_prod = {r_r_hi, 32'd0} + {32'd0, r_r_lo};
    assign rel_ok  = (r_xm < 64'(i_cfg.near_zero_band)) ? (r_em <= 64'(i_cfg.rel_tol))
                                                        : ({r_em, 32'd0} <= rel_prod);
    assign abs_ok  = (r_em <= {1'b0, i_cfg.abs_tol});
    assign add_neg = r_ep[63] ^ r_dneg ^ r_e[63];
    assign sum_w   = add_neg ? (66'(r_cmd.y) - 66'(r_pm)) : (66'(r_cmd.y) + 66'(r_pm));
    assign g_w     = (r_cmd.y == 64'sd0) ? ONE_Q32_W : 66'(r_cmd.y);

    assign o_stat.pop      = (r_state == S_IDLE) && i_head.valid;
    assign o_stat.clearing = (r_state == S_CLR);
    assign o_result_valid  = r_res_valid;
    assign o_result        = r_res;

    // Sequencer with its registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_sweep_ok  <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(NUM_VARS-1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.cmd;
                        r_state <= i_head.cmd.is_update ? S_ERR : S_INIT;
                    end
                end
                S_INIT: begin
                    r_res.next_guess      <= sat(g_w);
                    r_res.var_converged   <= 1'b0;
                    r_res.sweep_done      <= 1'b0;
                    r_res.sweep_converged <= 1'b0;
                    r_res_valid           <= 1'b1;
                    r_state               <= S_IDLE;
                end
                S_ERR: begin
                    r_e     <= e_sat;
                    r_ep    <= ep_rd;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_dneg  <= d_w[65];
                    r_dm    <= d_w[65] ? 64'(-d_w) : d_w[63:0];
                    r_epm   <= mag64(r_ep);
                    r_em    <= mag64(r_e);
                    r_xm    <= mag64(r_cmd.x);
                    r_state <= S_QSEL;
                end
                S_QSEL: begin
                    r_cnt <= '0;
                    r_rem <= r_epm;
                    if (r_dm == '0 || r_dm < 64'(i_cfg.near_zero_band)) begin
                        r_qm    <= '0;
                        r_state <= S_MUL1;
                    end else if (r_epm >= r_dm) begin
                        r_qm    <= ONE_Q1_32;
                        r_state <= S_MUL1;
                    end else begin
                        r_qm    <= '0;
                        r_state <= S_DIV;
                    end
                end
                // One quotient bit a cycle, 32 bits in all
                S_DIV: begin
                    r_rem <= div_bit ? 64'(div_r2 - {1'b0, r_dm}) : div_r2[63:0];
                    r_qm  <= {r_qm[31:0], div_bit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p_hi  <= 65'(r_qm * r_em[63:32]);
                    r_r_lo  <= r_xm[31:0] * i_cfg.rel_tol;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p_lo  <= 65'(r_qm * r_em[31:0]);
                    r_r_hi  <= r_xm[63:32] * i_cfg.rel_tol;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_pm    <= 64'(r_p_hi + (r_p_lo >> 32));
                    r_conv  <= abs_ok && rel_ok;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res.next_guess    <= sat(sum_w);
                    r_res.var_converged <= r_conv;
                    r_res.sweep_done    <= r_cmd.eos;
                    r_res.sweep_converged <= r_cmd.eos && r_sweep_ok && r_conv;
                    r_sweep_ok          <= r_cmd.eos ? 1'b1 : (r_sweep_ok && r_conv);
                    r_res_valid         <= 1'b1;
                    r_state             <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/wegstein_tear_update.sv @@
// Top level of the Wegstein tear-variable update block: register port,
// front queue and back datapath. Depends on wtu_pkg, wtu_front, wtu_back.
`timescale 1ns / 1ps

// An init item goes from the queue through S_INIT to its result. An update
// item goes through S_ERR, S_DIFF, S_QSEL, S_MUL1, S_MUL2, S_SUM, S_OUT, and
// also S_DIV after S_QSEL when it needs the quotient, which the shared
// divider forms one bit a cycle. Results appear on o_result for one cycle
// with o_result_valid and cannot be held off. Two items can wait in the
// queue; busy rises when it is full. After reset the error memory is
// cleared one entry a cycle, with busy high; register writes are taken
// meanwhile. Write registers only when no item is pending.
module wegstein_tear_update #(
    parameter int NUM_VARS   = wtu_pkg::NUM_VARS_DEF,
    parameter int VALUE_BITS = wtu_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  wtu_pkg::t_item   i_item,
    output logic             o_result_valid,
    output wtu_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import wtu_pkg::*;

    t_cfg       r_cfg;
    t_q_head    head;
    t_back_stat stat;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_tol        <= ABS_TOL_RST;
            r_cfg.rel_tol        <= REL_TOL_RST;
            r_cfg.near_zero_band <= NEAR_ZERO_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ABS_TOL:   r_cfg.abs_tol        <= pwdata[62:0];
                REG_REL_TOL:   r_cfg.rel_tol        <= pwdata[31:0];
                REG_NEAR_ZERO: r_cfg.near_zero_band <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_ABS_TOL:   prdata = {1'b0, r_cfg.abs_tol};
            REG_REL_TOL:   prdata = {32'd0, r_cfg.rel_tol};
            REG_NEAR_ZERO: prdata = {48'd0, r_cfg.near_zero_band};
            default:       prdata = '0;
        endcase
    end

    wtu_front #(.NUM_VARS(NUM_VARS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .o_busy (busy),
        .i_stat (stat),
        .o_head (head)
    );

    wtu_back #(.NUM_VARS(NUM_VARS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (head),
        .o_stat        (stat),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );
endmodule

@@ hdl/wtu_checker.sv @@
// Port-level checks for the Wegstein tear-variable update block, and the
// bind that attaches them. Depends on wtu_pkg and wegstein_tear_update.
`timescale 1ns / 1ps

module wtu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_result_valid,
    input wtu_pkg::t_result o_result,
    input logic             psel,
    input logic             penable,
    input logic             pready
);
    // Memory clearing keeps the block busy right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> busy)
        else $error("not busy after reset");

    // A sweep verdict only comes with a sweep end
    a_conv_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.sweep_converged |-> o_result.sweep_done)
        else $error("sweep_converged without sweep_done");

    // Each result is a single-cycle strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("pready low in access");
endmodule

bind wegstein_tear_update wtu_checker u_wtu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_result_valid(o_result_valid),
    .o_result      (o_result),
    .psel          (psel),
    .penable       (penable),
    .pready        (pready)
);

@@ verif/wtu_checker.sv @@
// Checker for the Wegstein tear-variable update block: watches the item,
// result and register channels, predicts each result and compares.
// Depends on wtu_pkg.
`timescale 1ns / 1ps

module wtu_scoreboard (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  wtu_pkg::t_item   i_item,
    input  logic             i_result_valid,
    input  wtu_pkg::t_result i_result,
    input  logic             i_psel,
    input  logic             i_penable,
    input  logic             i_pwrite,
    input  logic             i_pready,
    input  logic [4:0]       i_paddr,
    input  logic [63:0]      i_pwdata,
    output int               o_pending,
    output int               o_errors
);
    import wtu_pkg::*;

    localparam logic signed [65:0] VMAX = 66'sd9223372036854775807;
    localparam logic signed [65:0] VMIN = -66'sd9223372036854775808;

    // Shadow state of the block
    logic signed [63:0] err_mem [64];
    logic               all_conv;
    t_cfg               cfg;
    t_result            expected_q [$];

    assign o_pending = expected_q.size();

    function automatic logic signed [63:0] clip64(input logic signed [65:0] v);
        if (v > VMAX) return VMAX[63:0];
        if (v < VMIN) return VMIN[63:0];
        return v[63:0];
    endfunction

    // Next guess and convergence flags for one item; updates the shadow state
    function automatic t_result wegstein_next(input t_item it);
        t_result            r;
        logic signed [65:0] xw, yw, ew, pw, d, adj;
        logic signed [63:0] e, ep, g;
        logic [65:0]        dm, epm, em, xm;
        logic [97:0]        num, lhs, rhs;
        logic [32:0]        qm;
        logic [98:0]        prod;
        logic               dneg, qneg, abs_ok, rel_ok, conv;
        r = '0;
        xw = it.input_guess;
        yw = it.computed_value;
        if (it.req_type == REQ_INIT) begin
            g = (it.computed_value == 0) ? 64'sh1_0000_0000 : it.computed_value;
            err_mem[it.var_index] = '0;
            r.next_guess = g;
            return r;
        end
        e  = clip64(yw - xw);
        ep = err_mem[it.var_index];
        ew = e;
        pw = ep;
        d = ew - pw;
        dneg = d[65];
        dm = dneg ? -d : d;
        epm = ep[63] ? -pw : pw;
        em = e[63] ? -ew : ew;
        // slope factor, sign and magnitude in Q1.32
        if (dm == 0 || dm < {50'd0, cfg.near_zero_band}) qm = '0;
        else if (epm >= dm) qm = ONE_Q1_32;
        else begin
            num = {epm, 32'd0};
            num = num / dm;
            qm = num[32:0];
        end
        qneg = ep[63] ^ dneg;
        prod = qm * em;
        adj = {1'b0, prod[96:32]};
        if (qneg ^ e[63]) adj = -adj;
        r.next_guess = clip64(yw + adj);
        err_mem[it.var_index] = e;
        // convergence tests
        abs_ok = em <= {3'd0, cfg.abs_tol};
        xm = it.input_guess[63] ? -xw : xw;
        if (xm < {50'd0, cfg.near_zero_band}) rel_ok = em <= {34'd0, cfg.rel_tol};
        else begin
            lhs = {em, 32'd0};
            rhs = cfg.rel_tol * xm;
            rel_ok = lhs <= rhs;
        end
        conv = abs_ok && rel_ok;
        all_conv = all_conv && conv;
        r.var_converged = conv;
        if (it.end_of_sweep) begin
            r.sweep_done = 1'b1;
            r.sweep_converged = all_conv;
            all_conv = 1'b1;
        end
        return r;
    endfunction

    // Observe all channels at each edge
    always @(posedge i_clk) begin
        t_result want;
        int      nerr;
        nerr = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++) err_mem[i] = '0;
            all_conv = 1'b1;
            cfg.abs_tol = ABS_TOL_RST;
            cfg.rel_tol = REL_TOL_RST;
            cfg.near_zero_band = NEAR_ZERO_RST;
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:3])
                    REG_ABS_TOL:   cfg.abs_tol = i_pwdata[62:0];
                    REG_REL_TOL:   cfg.rel_tol = i_pwdata[31:0];
                    REG_NEAR_ZERO: cfg.near_zero_band = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) expected_q.push_back(wegstein_next(i_item));
            if (i_result_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: %p", i_result);
                    nerr++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.next_guess !== i_result.next_guess) begin
                        $error("next_guess exp %h got %h", want.next_guess,
                               i_result.next_guess);
                        nerr++;
                    end
                    if (want.var_converged !== i_result.var_converged) begin
                        $error("var_converged exp %b got %b", want.var_converged,
                               i_result.var_converged);
                        nerr++;
                    end
                    if (want.sweep_done !== i_result.sweep_done) begin
                        $error("sweep_done exp %b got %b", want.sweep_done,
                               i_result.sweep_done);
                        nerr++;
                    end
                    if (want.sweep_converged !== i_result.sweep_converged) begin
                        $error("sweep_converged exp %b got %b", want.sweep_converged,
                               i_result.sweep_converged);
                        nerr++;
                    end
                end
            end
            if (nerr != 0) o_errors <= o_errors + nerr;
        end
    end

endmodule

@@ verif/tb.sv @@
// Top of the Wegstein update testbench: clock, reset, register writes and
// item stimulus; checking is done by wtu_scoreboard. Depends on wtu_pkg,
// wtu_scoreboard and wegstein_tear_update.
`timescale 1ns / 1ps

module tb;
    import wtu_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          pending, errors;
    int          gap_pct;
    int          sent;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    wegstein_tear_update dut (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_valid, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    wtu_scoreboard chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_item,
        .i_result_valid(o_result_valid), .i_result(o_result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_pending(pending), .o_errors(errors)
    );

    // Hard stop
    initial begin
        #8_000_000;
        $display("FAIL wegstein_tear_update");
        $finish;
    end

    function automatic logic signed [63:0] rand_val();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        return v >>> $urandom_range(0, 63);
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'd0}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one item until taken, then idle at random
    task automatic send_item(input t_item it);
        i_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
        if ($urandom_range(99, 0) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic rq, input logic [5:0] ix,
                               input logic signed [63:0] x,
                               input logic signed [63:0] y, input logic eos);
        t_item it;
        it.req_type = rq; it.var_index = ix; it.input_guess = x;
        it.computed_value = y; it.end_of_sweep = eos;
        send_item(it);
    endtask

    // Init then a run of converging updates on one entry
    task automatic converge_seq(input logic eos_last);
        logic [5:0]         ix;
        logic signed [63:0] x, dl;
        int                 n;
        ix = 6'($urandom);
        x = rand_val();
        dl = rand_val();
        n = $urandom_range(2, 9);
        send_fields(REQ_INIT, ix, rand_val(), ($urandom_range(3, 0) == 0) ? 64'sd0 : x,
                    1'($urandom));
        for (int k = 0; k < n; k++) begin
            dl = dl >>> $urandom_range(0, 8);
            if ($urandom_range(1, 0)) dl = -dl;
            send_fields(REQ_UPDATE, ix, x, x + dl, eos_last && k == n - 1);
            x = x + dl;
        end
    endtask

    task automatic random_phase(input int target);
        int stop;
        t_item it;
        stop = sent + target;
        while (sent < stop) begin
            case ($urandom_range(9, 0))
                0, 1: begin
                    it = $bits(t_item)'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom});
                    send_item(it);
                end
                2, 3, 4: begin
                    // a sweep of updates on existing entries
                    for (int k = $urandom_range(4, 1); k > 0; k--) begin
                        logic signed [63:0] x;
                        x = rand_val();
                        send_fields(REQ_UPDATE, 6'($urandom), x,
                                    x + (rand_val() >>> $urandom_range(0, 40)), k == 1);
                    end
                end
                default: converge_seq(1'($urandom_range(1, 0)));
            endcase
        end
    endtask

    initial begin
        sent = 0;
        gap_pct = 21;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, both requests, sweep ends
        send_fields(REQ_INIT, 6'd0, 64'sd0, 64'sd0, 1'b1);
        send_fields(REQ_UPDATE, 6'd0, 64'sd0, 64'sd0, 1'b1);
        send_fields(REQ_INIT, 6'd63, -64'sd1, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_fields(REQ_INIT, 6'd1, 64'sd5, 64'sh8000_0000_0000_0000, 1'b0);
        send_fields(REQ_UPDATE, 6'd63, 64'sh8000_0000_0000_0000,
                    64'sh7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_fields(REQ_UPDATE, 6'd63, 64'sh7FFF_FFFF_FFFF_FFFF,
                    64'sh8000_0000_0000_0000, 1'b0);
        send_fields(REQ_UPDATE, 6'd63, 64'sh8000_0000_0000_0000,
                    64'sh7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_fields(REQ_UPDATE, 6'd2, 64'sh1_0000_0000, 64'sh1_0000_0010, 1'b0);
        send_fields(REQ_UPDATE, 6'd2, 64'sh1_0000_0010, 64'sh1_0000_0018, 1'b0);
        send_fields(REQ_UPDATE, 6'd2, 64'sh1_0000_0018, 64'sh1_0000_0018, 1'b1);
        send_fields(REQ_UPDATE, 6'd3, 64'sd0, 64'sd20, 1'b0);
        send_fields(REQ_UPDATE, 6'd3, 64'sd20, 64'sd20, 1'b1);
        send_fields(REQ_UPDATE, 6'd3, -64'sd100, 64'sd200, 1'b0);
        send_fields(REQ_UPDATE, 6'd3, 64'sd200, 64'sd201, 1'b1);
        drain();

        // phase with wide tolerances and the widest zero band
        reg_write(REG_ABS_TOL, 64'h7FFF_FFFF_FFFF_FFFF);
        reg_write(REG_REL_TOL, 64'hFFFF_FFFF);
        reg_write(REG_NEAR_ZERO, 64'hFFFF);
        random_phase(250);
        // wait for every result once mid-run
        drain();

        // tight tolerances, no band
        gap_pct = 51;
        reg_write(REG_ABS_TOL, 64'd0);
        reg_write(REG_REL_TOL, 64'd0);
        reg_write(REG_NEAR_ZERO, 64'd0);
        random_phase(250);
        drain();

        // moderate tolerances, back to back
        gap_pct = 0;
        reg_write(REG_ABS_TOL, 64'h0000_0000_0010_0000);
        reg_write(REG_REL_TOL, 64'h0100_0000);
        reg_write(REG_NEAR_ZERO, 64'd16);
        random_phase(280);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("PASS wegstein_tear_update");
        end else begin
            $display("FAIL wegstein_tear_update");
        end
        $finish;
    end

endmodule
